/* design/ujse_pkg.sv */
package ujse_pkg;

  localparam int MaxRun = 12;

  typedef logic [6:0] char_t;
  typedef logic [MaxRun-1:0][6:0] char_row_t;
  typedef logic [5:0][6:0] uesc_t;
  typedef logic [1:0] err_t;

  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_END  = 2'd1;
  localparam err_t ERR_SEQ  = 2'd2;

  localparam char_t BslChar = 7'h5C;
  localparam char_t UChar   = 7'h75;

  // decoder state carried between bytes
  typedef struct packed {
    logic [1:0]  need;
    logic [20:0] acc;
    logic [1:0]  kind;
    logic        bad;
    logic        disc;
  } dec_state_t;

  // all results caused by one byte
  typedef struct packed {
    char_row_t   chars;
    logic [3:0]  cnt;
    logic        has_char;
    err_t        err;
    logic        done;
  } run_t;

  typedef struct packed {
    logic free;
  } ser_stat_t;

  function automatic char_t hex_digit(input logic [3:0] v);
    return {3'b000, v} + ((v < 4'd10) ? 7'h30 : 7'h37);
  endfunction

  // element 0 goes out first
  function automatic uesc_t u_esc(input logic [15:0] v);
    uesc_t r;
    r[0] = BslChar;
    r[1] = UChar;
    r[2] = hex_digit(v[15:12]);
    r[3] = hex_digit(v[11:8]);
    r[4] = hex_digit(v[7:4]);
    r[5] = hex_digit(v[3:0]);
    return r;
  endfunction

endpackage

/* design/ujse_in_if.sv */
interface ujse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

/* design/ujse_out_if.sv */
interface ujse_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       char_valid;
  logic [1:0] error_code;
  logic       string_done;
  logic       run_last;

  modport source (output valid, output out_char, output char_valid, output error_code,
                  output string_done, output run_last, input ready);
  modport sink (input valid, input out_char, input char_valid, input error_code,
                input string_done, input run_last, output ready);
endinterface

/* design/ujse_decode.sv */
module ujse_decode (
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  input  ujse_pkg::dec_state_t st,
  output ujse_pkg::dec_state_t st_nxt,
  output ujse_pkg::run_t       run
);
  import ujse_pkg::*;

  logic [20:0] acc_n;
  logic [20:0] sv;
  logic [1:0]  need_n;
  logic        bad_n;
  logic [1:0]  lead_kind;
  logic [20:0] lead_bits;
  char_t       esc;

  always_comb begin
    acc_n  = {st.acc[14:0], byte_i[5:0]};
    need_n = st.need - 2'd1;
    bad_n  = st.bad | (byte_i[7:6] != 2'b10);
    sv     = acc_n - 21'h10000;

    unique casez (byte_i)
      8'b110?????: begin lead_kind = 2'd1; lead_bits = {16'b0, byte_i[4:0]}; end
      8'b1110????: begin lead_kind = 2'd2; lead_bits = {17'b0, byte_i[3:0]}; end
      8'b11110???: begin lead_kind = 2'd3; lead_bits = {18'b0, byte_i[2:0]}; end
      default:     begin lead_kind = 2'd0; lead_bits = '0; end
    endcase

    case (byte_i[6:0])
      7'h08:   esc = 7'h62;
      7'h09:   esc = 7'h74;
      7'h0A:   esc = 7'h6E;
      7'h0C:   esc = 7'h66;
      7'h0D:   esc = 7'h72;
      7'h22:   esc = 7'h22;
      7'h2F:   esc = 7'h2F;
      7'h5C:   esc = BslChar;
      default: esc = 7'h00;
    endcase

    st_nxt       = st;
    run.chars    = '0;
    run.cnt      = 4'd0;
    run.has_char = 1'b1;
    run.err      = ERR_NONE;
    run.done     = 1'b0;

    if (st.disc) begin
      // dropping until string end
    end else if (st.need != 2'd0) begin
      st_nxt.acc  = acc_n;
      st_nxt.need = need_n;
      st_nxt.bad  = bad_n;
      if (need_n != 2'd0) begin
        if (end_i) begin
          run.cnt = 4'd1; run.has_char = 1'b0; run.err = ERR_END;
        end
      end else if (bad_n) begin
        run.cnt = 4'd1; run.has_char = 1'b0; run.err = ERR_SEQ;
        st_nxt.disc = 1'b1;
      end else if (st.kind == 2'd3) begin
        run.chars[5:0]  = u_esc({6'b110110, sv[19:10]});
        run.chars[11:6] = u_esc({6'b110111, sv[9:0]});
        run.cnt         = 4'(MaxRun);
        st_nxt.kind     = 2'd0;
      end else begin
        run.chars[5:0] = u_esc(acc_n[15:0]);
        run.cnt        = 4'd6;
        st_nxt.kind    = 2'd0;
      end
    end else if (!byte_i[7]) begin
      if (esc != 7'h00) begin
        run.chars[0] = BslChar;
        run.chars[1] = esc;
        run.cnt      = 4'd2;
      end else if (byte_i[6:5] == 2'b00) begin
        run.chars[5:0] = u_esc({9'b0, byte_i[6:0]});
        run.cnt        = 4'd6;
      end else begin
        run.chars[0] = byte_i[6:0];
        run.cnt      = 4'd1;
      end
    end else if (lead_kind != 2'd0) begin
      st_nxt.kind = lead_kind;
      st_nxt.need = lead_kind;
      st_nxt.acc  = lead_bits;
      st_nxt.bad  = 1'b0;
      if (end_i) begin
        run.cnt = 4'd1; run.has_char = 1'b0; run.err = ERR_END;
      end
    end

    if (end_i) begin
      if (run.cnt == 4'd0) begin
        run.cnt = 4'd1; run.has_char = 1'b0;
      end
      run.done = 1'b1;
      st_nxt   = '0;
    end
  end

endmodule

/* design/ujse_serial.sv */
module ujse_serial (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ujse_pkg::run_t    run_in,
  output ujse_pkg::ser_stat_t stat,
  ujse_out_if.source        out_if
);
  import ujse_pkg::*;

  logic       b_valid_r;
  run_t       run_r;
  logic [3:0] idx_r;
  logic       last;
  logic       take;

  assign last = (idx_r == run_r.cnt - 4'd1);
  assign take = b_valid_r && out_if.ready;

  assign stat.free      = !b_valid_r || (take && last);

  assign out_if.valid       = b_valid_r;
  assign out_if.out_char    = run_r.has_char ? run_r.chars[idx_r] : 7'h00;
  assign out_if.char_valid  = run_r.has_char;
  assign out_if.error_code  = run_r.err;
  assign out_if.string_done = run_r.done && last;
  assign out_if.run_last    = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      idx_r     <= 4'd0;
    end else if (load) begin
      b_valid_r <= 1'b1;
      idx_r     <= 4'd0;
    end else if (take) begin
      if (last) begin
        b_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run_r <= run_in;
    end
  end

endmodule

/* design/utf8_to_json_string_escaper.sv */
// channel  dir  signals                                                 word
// in_if    in   valid ready in_byte[7:0] string_end                     one UTF-8 byte
// out_if   out  valid ready out_char[6:0] char_valid error_code[1:0]    one ASCII char
//               string_done run_last                                    or error/end mark
// A byte waits in the input register, is decoded into a run of 0 to 12 results,
// and the run register emits it one word per cycle while out_if.ready is high.
// A byte giving one result or none is taken each cycle while out_if is ready; a
// longer run holds the input until the run register has drained it.
// Synchronous active-low reset clears valids and decoder state.
// A stalled output holds the run; one more byte can wait in the input register.
module utf8_to_json_string_escaper (
  input logic        clk,
  input logic        rst_n,
  ujse_in_if.sink    in_if,
  ujse_out_if.source out_if
);
  import ujse_pkg::*;

  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_end_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  run_t       run;
  ser_stat_t  stat;
  logic       a_move;
  logic       load;

  ujse_decode u_dec (
    .byte_i (a_byte_r),
    .end_i  (a_end_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .run    (run)
  );

  ujse_serial u_ser (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .run_in (run),
    .stat   (stat),
    .out_if (out_if)
  );

  // runs with no result retire without touching the run register
  assign a_move      = a_valid_r && ((run.cnt == 4'd0) || stat.free);
  assign load        = a_move && (run.cnt != 4'd0);
  assign in_if.ready = !a_valid_r || a_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (in_if.ready) begin
        a_valid_r <= in_if.valid;
      end
      if (a_move) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      a_byte_r <= in_if.in_byte;
      a_end_r  <= in_if.string_end;
    end
  end

  a_err_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.error_code != ERR_NONE) |-> !out_if.char_valid)
    else $error("error word carries a character");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.string_done |-> out_if.run_last)
    else $error("string end not on last word of run");

  a_disc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.disc |-> (st_r.need == 2'd0))
    else $error("discarding with an open sequence");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (run.cnt <= 4'(MaxRun)) && !(stat.free == 1'b0))
    else $error("run loaded while run register busy or too long");

endmodule

/* dv/ujse_checker.sv */
module ujse_checker
  import ujse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ujse_in_if   in_mon,
  ujse_out_if  out_mon,
  output int   fail_count,
  output int   words_open,
  output int   words_checked,
  output int   error_marks
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SEQ_NONE  = 2'd0,
    SEQ_TWO   = 2'd1,
    SEQ_THREE = 2'd2,
    SEQ_FOUR  = 2'd3
  } seq_kind_t;

  typedef struct packed {
    char_t ch;
    logic  cv;
    err_t  err;
    logic  done;
    logic  last;
  } esc_word_t;

  // decoder copy
  logic [1:0]  dec_need;
  logic [20:0] dec_acc;
  seq_kind_t   dec_kind;
  logic        dec_bad;
  logic        dec_disc;

  esc_word_t run_words[$];
  esc_word_t escaped_q[$];

  function automatic void add_word(char_t ch, logic cv, err_t err);
    esc_word_t w;
    w.ch   = ch;
    w.cv   = cv;
    w.err  = err;
    w.done = 1'b0;
    w.last = 1'b0;
    run_words.push_back(w);
  endfunction

  function automatic char_t nibble_char(logic [3:0] n);
    char_t c;
    if (n < 4'd10) c = 7'h30 + {3'b000, n};
    else c = 7'h41 + {3'b000, n} - 7'd10;
    return c;
  endfunction

  function automatic void add_uesc(logic [15:0] v);
    add_word(BslChar, 1'b1, ERR_NONE);
    add_word(UChar, 1'b1, ERR_NONE);
    add_word(nibble_char(v[15:12]), 1'b1, ERR_NONE);
    add_word(nibble_char(v[11:8]), 1'b1, ERR_NONE);
    add_word(nibble_char(v[7:4]), 1'b1, ERR_NONE);
    add_word(nibble_char(v[3:0]), 1'b1, ERR_NONE);
  endfunction

  function automatic void add_ascii(logic [6:0] c);
    logic [7:0] esc;
    esc = 8'h00;
    case (c)
      7'h08: esc = "b";
      7'h09: esc = "t";
      7'h0A: esc = "n";
      7'h0C: esc = "f";
      7'h0D: esc = "r";
      7'h22: esc = "\"";
      7'h2F: esc = "/";
      7'h5C: esc = "\\";
      default: if (c < 7'h20) esc = "u";
    endcase
    if (esc == "u") begin
      add_uesc({9'd0, c});
    end else if (esc != 8'h00) begin
      add_word(BslChar, 1'b1, ERR_NONE);
      add_word(esc[6:0], 1'b1, ERR_NONE);
    end else begin
      add_word(c, 1'b1, ERR_NONE);
    end
  endfunction

  function automatic void clear_decoder();
    dec_need = 2'd0;
    dec_acc  = 21'd0;
    dec_kind = SEQ_NONE;
    dec_bad  = 1'b0;
    dec_disc = 1'b0;
  endfunction

  function automatic void escape_byte(logic [7:0] b, logic fin);
    logic [20:0] v;
    seq_kind_t   kind;
    logic [20:0] bits;
    run_words.delete();
    kind = SEQ_NONE;
    bits = 21'd0;
    if (dec_disc) begin
      // dropped until the string ends
    end else if (dec_need != 2'd0) begin
      if (b[7:6] != 2'b10) dec_bad = 1'b1;
      dec_acc  = {dec_acc[14:0], b[5:0]};
      dec_need = dec_need - 2'd1;
      if (dec_need != 2'd0) begin
        if (fin) add_word(7'h00, 1'b0, ERR_END);
      end else if (dec_bad) begin
        add_word(7'h00, 1'b0, ERR_SEQ);
        dec_disc = 1'b1;
      end else if (dec_kind == SEQ_FOUR) begin
        v = dec_acc - 21'h10000;
        add_uesc(16'hD800 + {6'd0, v[19:10]});
        add_uesc(16'hDC00 + {6'd0, v[9:0]});
        dec_kind = SEQ_NONE;
      end else begin
        add_uesc(dec_acc[15:0]);
        dec_kind = SEQ_NONE;
      end
    end else if (!b[7]) begin
      add_ascii(b[6:0]);
    end else begin
      casez (b)
        8'b110?????: begin kind = SEQ_TWO;   bits = {16'd0, b[4:0]}; end
        8'b1110????: begin kind = SEQ_THREE; bits = {17'd0, b[3:0]}; end
        8'b11110???: begin kind = SEQ_FOUR;  bits = {18'd0, b[2:0]}; end
        default:     kind = SEQ_NONE;
      endcase
      if (kind != SEQ_NONE) begin
        dec_kind = kind;
        dec_need = kind;
        dec_acc  = bits;
        dec_bad  = 1'b0;
        if (fin) add_word(7'h00, 1'b0, ERR_END);
      end
    end
    if (fin) begin
      if (run_words.size() == 0) add_word(7'h00, 1'b0, ERR_NONE);
      run_words[run_words.size()-1].done = 1'b1;
      clear_decoder();
    end
    if (run_words.size() > 0) run_words[run_words.size()-1].last = 1'b1;
    foreach (run_words[i]) escaped_q.push_back(run_words[i]);
  endfunction

  initial begin
    fail_count    = 0;
    words_open    = 0;
    words_checked = 0;
    error_marks   = 0;
    clear_decoder();
  end

  always @(posedge clk) begin
    esc_word_t want;
    if (!rst_n) begin
      clear_decoder();
      escaped_q.delete();
    end else begin
      // output first: a byte taken at this edge cannot yet have a word out
      if (out_mon.valid && out_mon.ready) begin
        if (escaped_q.size() == 0) begin
          fail_count++;
          $display("%0t: word with nothing expected: ch=%h cv=%b err=%0d done=%b last=%b",
                   $time, out_mon.out_char, out_mon.char_valid, out_mon.error_code,
                   out_mon.string_done, out_mon.run_last);
        end else begin
          want = escaped_q.pop_front();
          words_checked++;
          if (want.err != ERR_NONE) error_marks++;
          if (out_mon.out_char !== want.ch || out_mon.char_valid !== want.cv ||
              out_mon.error_code !== want.err || out_mon.string_done !== want.done ||
              out_mon.run_last !== want.last) begin
            fail_count++;
            $display("%0t: mismatch exp ch=%h cv=%b err=%0d done=%b last=%b,",
                     $time, want.ch, want.cv, want.err, want.done, want.last,
                     " got ch=%h cv=%b err=%0d done=%b last=%b",
                     out_mon.out_char, out_mon.char_valid, out_mon.error_code,
                     out_mon.string_done, out_mon.run_last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) escape_byte(in_mon.in_byte, in_mon.string_end);
    end
    words_open = escaped_q.size();
  end

endmodule

/* dv/tb_utf8_to_json_string_escaper.sv */
module tb_utf8_to_json_string_escaper;
  timeunit 1ns;
  timeprecision 1ps;

  import ujse_pkg::*;

  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 250;
  localparam int TailCycles  = 40;
  localparam int RandomBytes = 352;

  logic clk = 1'b0;
  logic rst_n;
  logic hold = 1'b0;
  logic send_calm = 1'b0;
  logic sink_calm = 1'b0;
  int   bytes_sent = 0;
  int   strings_sent = 0;
  int   sink_words = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   words_open;
  int   words_checked;
  int   error_marks;

  logic [7:0] utf8_str[$];

  ujse_in_if  in_ch();
  ujse_out_if out_ch();

  utf8_to_json_string_escaper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  ujse_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .words_open    (words_open),
    .words_checked (words_checked),
    .error_marks   (error_marks)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.string_end <= fin;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_str();
    foreach (utf8_str[i]) send_byte(utf8_str[i], i == utf8_str.size() - 1);
    strings_sent++;
  endtask

  function automatic logic [7:0] pick_special();
    int r;
    logic [7:0] b;
    r = $urandom_range(0, 35);
    case (r)
      32:      b = 8'h22;
      33:      b = 8'h2F;
      34:      b = 8'h5C;
      35:      b = 8'h7F;
      default: b = 8'(r);
    endcase
    return b;
  endfunction

  function automatic logic [7:0] lead_byte(int kind);
    logic [7:0] b;
    case (kind)
      1:       b = 8'hC0 | 8'($urandom_range(0, 31));
      2:       b = 8'hE0 | 8'($urandom_range(0, 15));
      default: b = 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // anything that is not 10xxxxxx
  function automatic logic [7:0] bad_byte();
    int r;
    r = $urandom_range(0, 191);
    return (r < 128) ? 8'(r) : 8'(r + 64);
  endfunction

  function automatic void build_random_string();
    int tokens;
    int pick;
    int kind;
    int good;
    tokens = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
    utf8_str.delete();
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        utf8_str.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 45) begin
        utf8_str.push_back(pick_special());
      end else if (pick < 80) begin
        kind = $urandom_range(1, 3);
        utf8_str.push_back(lead_byte(kind));
        repeat (kind) utf8_str.push_back(cont_byte());
      end else if (pick < 88) begin
        kind = $urandom_range(1, 3);
        good = $urandom_range(0, kind - 1);
        utf8_str.push_back(lead_byte(kind));
        repeat (good) utf8_str.push_back(cont_byte());
        // either a bad continuation or a string cut mid-sequence
        if ($urandom_range(0, 1) == 1) utf8_str.push_back(bad_byte());
        else break;
      end else begin
        utf8_str.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // receiver
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (sink_words % 16 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      stall = sink_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0 || hold) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sink_words++;
    end
  end

  // long receiver hold-offs while bytes keep coming
  initial begin
    wait (bytes_sent >= 60);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold <= 1'b0;
    wait (bytes_sent >= 260);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("watchdog: no handshake for %0d cycles at %0t", IdleLimit, $time);
      $display("tb_utf8_to_json_string_escaper: errors");
      $finish;
    end
  end

  initial begin
    int directed;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= 8'h00;
    in_ch.string_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table escapes, control bytes and plain ASCII
    utf8_str = '{8'h00, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h22, 8'h2F, 8'h5C, 8'h1F,
                 8'h41, 8'h7F};
    send_str();
    // two-, three- and four-byte forms, stray continuation, F8+ byte on the end
    utf8_str = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80,
                 8'hFF};
    send_str();
    // string ends on a lead byte
    utf8_str = '{8'hC3};
    send_str();
    // bad continuation, then dropped up to the end
    utf8_str = '{8'hE2, 8'h41, 8'h82, 8'h7A};
    send_str();
    directed = bytes_sent;

    while (bytes_sent < directed + RandomBytes) begin
      send_calm = ($urandom_range(0, 4) == 0);
      build_random_string();
      send_str();
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (words_open != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("%0d bytes in %0d strings sent; %0d words checked, %0d of them error marks",
             bytes_sent, strings_sent, words_checked, error_marks);
    if (fail_count == 0 && words_open == 0) begin
      $display("tb_utf8_to_json_string_escaper: clean");
    end else begin
      $display("tb_utf8_to_json_string_escaper: errors");
    end
    $finish;
  end

endmodule
